// File: sv/scr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

	localparam int INDEX_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int TIME_W     = 24;
	localparam int WB         = 30;

	localparam int Q_W    = WB + 1;
	localparam int K_W    = Q_W + 3;
	localparam int SUM_W  = Q_W + 4;
	localparam int POS_W  = FRAC_BITS + 1;
	localparam int CFG_W  = (TIME_W > INDEX_BITS) ? TIME_W : INDEX_BITS;
	localparam int CFG_IDX_W = 2;

	localparam int DIV_QB = WB + 1;
	localparam int U_NW   = INDEX_BITS + 1 + WB;
	localparam int R_NW   = TIME_W + 1 + WB;
	localparam int P_NW   = SUM_W + FRAC_BITS + 1;
	localparam int NW_AB  = (U_NW > R_NW) ? U_NW : R_NW;
	localparam int DIV_NW = (NW_AB > P_NW) ? NW_AB : P_NW;
	localparam int DW_AB  = (INDEX_BITS > TIME_W) ? INDEX_BITS : TIME_W;
	localparam int DIV_DW = (DW_AB > SUM_W + 1) ? DW_AB : SUM_W + 1;
	localparam int DIV_CW = DIV_DW + DIV_QB;

	localparam int SHP_LAT = 4;

	localparam logic [Q_W-1:0]   WONE  = {1'b1, {WB{1'b0}}};
	localparam logic [POS_W-1:0] PONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [POS_W-1:0] PHALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_CUBIC  = 2'd0,
		MODE_ACCEL  = 2'd1,
		MODE_CRUISE = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DURATION = 2'd0,
		REG_COUNT    = 2'd1,
		REG_JERK     = 2'd2,
		REG_ACCEL    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [Q_W-1:0] x;
		logic [Q_W-1:0] a;
		logic [Q_W-1:0] b;
		logic           lj;
		logic           la;
		mode_t          mode;
	} shp_in_t;

	typedef struct packed {
		logic  valid;
		logic  full;
		logic  zero;
		logic  sub;
		mode_t mode;
		logic  lj;
		logic  la;
		logic  azero;
		logic  aclamp;
		logic  bzero;
		logic  bclamp;
		logic  sat;
		logic  dz;
	} side_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		mode_t            mode;
	} res_t;

	// Fixed-point product of two Q1.30 values, truncated.
	function automatic logic [Q_W-1:0] qm(input logic [Q_W-1:0] x, input logic [Q_W-1:0] y);
		logic [2*Q_W-1:0] p;
		p = x * y;
		return p[WB+Q_W-1:WB];
	endfunction

endpackage

`default_nettype wire

// File: sv/scr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scr_in_if;
	import scr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] sample_index;
	modport source (output valid, output sample_index, input ready);
	modport sink (input valid, input sample_index, output ready);
endinterface

interface scr_out_if;
	import scr_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position_ratio;
	logic [1:0]       profile_mode;
	modport source (output valid, output position_ratio, output profile_mode, input ready);
	modport sink (input valid, input position_ratio, input profile_mode, output ready);
endinterface

`default_nettype wire

// File: sv/scr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage.
module scr_div (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [scr_pkg::DIV_NW-1:0] num,
	input  wire logic [scr_pkg::DIV_DW-1:0] den,
	output logic      [scr_pkg::DIV_QB-1:0] quot
);
	import scr_pkg::*;

	logic [DIV_NW-1:0] rem_s [DIV_QB];
	logic [DIV_DW-1:0] dv_s  [DIV_QB];
	logic [DIV_QB-1:0] q_s   [DIV_QB];

	for (genvar j = 0; j < DIV_QB; j++) begin : g_stage
		localparam int SH = DIV_QB - 1 - j;
		logic [DIV_NW-1:0] rem_in;
		logic [DIV_DW-1:0] dv_in;
		logic [DIV_QB-1:0] q_in;
		logic [DIV_CW-1:0] trial;
		logic [DIV_CW-1:0] rem_w;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign dv_in  = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign dv_in  = dv_s[j-1];
			assign q_in   = q_s[j-1];
		end

		assign trial = DIV_CW'(dv_in) << SH;
		assign rem_w = DIV_CW'(rem_in);
		assign ge    = rem_w >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? DIV_NW'(rem_w - trial) : rem_in;
				dv_s[j]  <= dv_in;
				q_s[j]   <= {q_in[DIV_QB-2:0], ge};
			end
		end
	end

	assign quot = q_s[DIV_QB-1];

endmodule

`default_nettype wire

// File: sv/scr_shape.sv
`timescale 1ns / 1ps
`default_nettype none

// Evaluates the profile polynomial at the sample point (num) and at mid-move (den).
module scr_shape (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire scr_pkg::shp_in_t          din,
	output logic      [scr_pkg::SUM_W-1:0] num,
	output logic      [scr_pkg::SUM_W-1:0] den
);
	import scr_pkg::*;

	function automatic logic [SUM_W-1:0] x3w(input logic [Q_W-1:0] v);
		return (SUM_W'(v) << 1) + SUM_W'(v);
	endfunction

	// Stage 1
	logic [Q_W-1:0] ab_w;
	logic [Q_W:0]   sum_ab;
	logic [Q_W-1:0] d_w, e_w, gd_w, ge_w;
	logic [Q_W-1:0] a_s1, a2_s1, ab_s1, b2_s1, x_s1, x2_s1, b_s1;
	logic [Q_W-1:0] d_s1, e_s1, gd_s1, ge_s1;
	logic           lj_s1, la_s1;
	mode_t          mode_s1;

	always_comb begin
		ab_w   = qm(din.a, din.b);
		sum_ab = {1'b0, din.a} + {1'b0, din.b};
		d_w    = (din.x > din.a) ? din.x - din.a : '0;
		e_w    = ({1'b0, din.x} > sum_ab) ? Q_W'({1'b0, din.x} - sum_ab) : '0;
		gd_w   = (WONE > din.a) ? WONE - din.a : '0;
		ge_w   = ({1'b0, WONE} > sum_ab) ? Q_W'({1'b0, WONE} - sum_ab) : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= din.a;
			b_s1    <= din.b;
			x_s1    <= din.x;
			a2_s1   <= qm(din.a, din.a);
			ab_s1   <= ab_w;
			b2_s1   <= qm(din.b, din.b);
			x2_s1   <= qm(din.x, din.x);
			d_s1    <= d_w;
			e_s1    <= e_w;
			gd_s1   <= gd_w;
			ge_s1   <= ge_w;
			lj_s1   <= din.lj;
			la_s1   <= din.la;
			mode_s1 <= din.mode;
		end
	end

	// Stage 2
	logic [Q_W-1:0] a_s2, a3_s2, a2b_s2, ab2_s2, x3_s2, dd_s2, a2d_s2, gdd_s2, a2gd_s2;
	logic [Q_W-1:0] e_s2, ge_s2;
	logic [K_W-1:0] k_s2;
	logic           lj_s2, la_s2;
	mode_t          mode_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= a_s1;
			a3_s2   <= qm(a2_s1, a_s1);
			a2b_s2  <= qm(a2_s1, b_s1);
			ab2_s2  <= qm(a_s1, b2_s1);
			x3_s2   <= qm(x2_s1, x_s1);
			dd_s2   <= qm(d_s1, d_s1);
			a2d_s2  <= qm(a2_s1, d_s1);
			gdd_s2  <= qm(gd_s1, gd_s1);
			a2gd_s2 <= qm(a2_s1, gd_s1);
			k_s2    <= (K_W'(a2_s1) << 1) + K_W'(a2_s1) + (K_W'(ab_s1) << 2)
				+ (K_W'(ab_s1) << 1);
			e_s2    <= e_s1;
			ge_s2   <= ge_s1;
			lj_s2   <= lj_s1;
			la_s2   <= la_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3
	logic [K_W+Q_W-1:0] ke_p, kge_p;
	logic [Q_W-1:0]     add_s3, gadd_s3, a3_s3, a2b_s3, ab2_s3, x3_s3, a2d_s3, a2gd_s3;
	logic [SUM_W-1:0]   ke_s3, kge_s3;
	logic               lj_s3, la_s3;
	mode_t              mode_s3;

	always_comb begin
		ke_p  = k_s2 * e_s2;
		kge_p = k_s2 * ge_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			add_s3  <= qm(a_s2, dd_s2);
			gadd_s3 <= qm(a_s2, gdd_s2);
			ke_s3   <= ke_p[WB+SUM_W-1:WB];
			kge_s3  <= kge_p[WB+SUM_W-1:WB];
			a3_s3   <= a3_s2;
			a2b_s3  <= a2b_s2;
			ab2_s3  <= ab2_s2;
			x3_s3   <= x3_s2;
			a2d_s3  <= a2d_s2;
			a2gd_s3 <= a2gd_s2;
			lj_s3   <= lj_s2;
			la_s3   <= la_s2;
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4
	logic [SUM_W-1:0] base_w, num_w, den_w, num_s4, den_s4;

	always_comb begin
		base_w = SUM_W'(a3_s3) + x3w(a2b_s3) + x3w(ab2_s3);
		if (lj_s3) begin
			num_w = SUM_W'(x3_s3);
		end else if (la_s3) begin
			num_w = SUM_W'(a3_s3) + x3w(a2d_s3) + x3w(add_s3);
		end else begin
			num_w = base_w + ke_s3;
		end
		if (mode_s3 == MODE_CUBIC) begin
			den_w = SUM_W'(WONE);
		end else if (mode_s3 == MODE_ACCEL) begin
			den_w = SUM_W'(a3_s3) + x3w(a2gd_s3) + x3w(gadd_s3);
		end else begin
			den_w = base_w + kge_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= num_w;
			den_s4 <= den_w;
		end
	end

	assign num = num_s4;
	assign den = den_s4;

endmodule

`default_nettype wire

// File: sv/scr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue; the pipeline advances while a slot is free or being freed.
module scr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire scr_pkg::res_t din,
	output logic               adv,
	scr_out_if.source          result
);
	import scr_pkg::*;

	logic [1:0] cnt_q;
	res_t       slot0_q, slot1_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && result.ready;
	assign adv = (cnt_q != 2'd2) || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= din;
			end else begin
				slot1_q <= din;
			end
		end else if (pop && !push) begin
			slot0_q <= slot1_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				slot0_q <= din;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= din;
			end
		end
	end

	assign result.valid          = cnt_q != 2'd0;
	assign result.position_ratio = slot0_q.pos;
	assign result.profile_mode   = slot0_q.mode;

endmodule

`default_nettype wire

// File: sv/s_curve_position_ratio_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// S-curve position lookup. Each item on the sample channel carries a sample
// index; the block returns on the result channel the normalized position of
// the configured jerk-limited move at that index (Q1.16, 65536 is 1.0) and
// the profile regime that the registers select.
// Registers are written through cfg_we/cfg_index/cfg_data: 0 move duration,
// 1 sample count, 2 jerk time, 3 accel time. The user must write them only
// while no item is in flight; the block itself does not enforce it. It takes
// one item per cycle while sample.ready is high; two 31-stage bit-per-stage
// dividers (sample point and final ratio) frame a 4-stage multiply pipeline.
// Results leave in input order through a two-entry output queue. While the
// receiver stalls the pipeline keeps moving until the queue holds two items,
// then the whole pipeline holds and sample.ready drops; nothing is lost.
// Reset empties the pipeline and the queue and loads the default registers
// (duration 1.0 s, 101 samples, jerk 0.2 s, accel 0.3 s).
module s_curve_position_ratio_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [scr_pkg::CFG_W-1:0]     cfg_data,
	scr_in_if.sink                             sample,
	scr_out_if.source                          result
);
	import scr_pkg::*;

	localparam int PE_W  = INDEX_BITS + TIME_W;
	localparam int PJA_W = INDEX_BITS + TIME_W + 1;

	// Configuration registers
	logic [TIME_W-1:0]     dur_q, jerk_q, acc_q;
	logic [INDEX_BITS-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q  <= TIME_W'(65536);
			cnt_q  <= INDEX_BITS'(101);
			jerk_q <= TIME_W'(13107);
			acc_q  <= TIME_W'(19661);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DURATION: dur_q  <= cfg_data[TIME_W-1:0];
				REG_COUNT:    cnt_q  <= cfg_data[INDEX_BITS-1:0];
				REG_JERK:     jerk_q <= cfg_data[TIME_W-1:0];
				REG_ACCEL:    acc_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;

	// Entry stage
	logic [INDEX_BITS-1:0] idx, d_w, e_w;
	logic [INDEX_BITS:0]   twice_i;
	logic [TIME_W:0]       jerk2, acc2, jsum;
	logic [TIME_W+1:0]     jsum2;
	mode_t                 mode_w;
	side_t                 side_w;

	always_comb begin
		idx     = sample.sample_index;
		d_w     = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
		twice_i = {idx, 1'b0};
		e_w     = (twice_i <= {1'b0, d_w}) ? idx : d_w - idx;
		jerk2   = {jerk_q, 1'b0};
		acc2    = {acc_q, 1'b0};
		jsum    = {1'b0, jerk_q} + {1'b0, acc_q};
		jsum2   = {jsum, 1'b0};
		if ({1'b0, dur_q} < jerk2) begin
			mode_w = MODE_CUBIC;
		end else if ({2'b00, dur_q} < jsum2) begin
			mode_w = MODE_ACCEL;
		end else begin
			mode_w = MODE_CRUISE;
		end
		side_w        = '0;
		side_w.valid  = sample.valid;
		side_w.full   = idx >= d_w;
		side_w.zero   = idx == '0;
		side_w.sub    = twice_i >= {1'b0, d_w};
		side_w.mode   = mode_w;
		side_w.azero  = dur_q == '0;
		side_w.aclamp = jerk2 >= {1'b0, dur_q};
		side_w.bzero  = dur_q == '0;
		side_w.bclamp = acc2 >= {1'b0, dur_q};
	end

	side_t                 side_s1;
	logic [INDEX_BITS-1:0] d_s1, e_s1;
	logic [PE_W-1:0]       pe_s1, pj_s1;
	logic [PJA_W-1:0]      pja_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_w;
			e_s1   <= e_w;
			pe_s1  <= e_w * dur_q;
			pj_s1  <= jerk_q * d_w;
			pja_s1 <= jsum * d_w;
		end
	end

	// Sample point and phase fractions
	logic [DIV_QB-1:0] u_q, a_qt, b_qt;

	scr_div u_div_u (
		.clk  (clk),
		.en   (en),
		.num  (DIV_NW'(e_s1) << (WB + 1)),
		.den  (DIV_DW'(d_s1)),
		.quot (u_q)
	);

	scr_div u_div_a (
		.clk  (clk),
		.en   (en),
		.num  (DIV_NW'(jerk_q) << (WB + 1)),
		.den  (DIV_DW'(dur_q)),
		.quot (a_qt)
	);

	scr_div u_div_b (
		.clk  (clk),
		.en   (en),
		.num  (DIV_NW'(acc_q) << (WB + 1)),
		.den  (DIV_DW'(dur_q)),
		.quot (b_qt)
	);

	side_t side_a_in;
	side_t line_a [DIV_QB];

	always_comb begin
		side_a_in    = side_s1;
		side_a_in.lj = PJA_W'(pe_s1) < PJA_W'(pj_s1);
		side_a_in.la = PJA_W'(pe_s1) < pja_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DIV_QB; n++) line_a[n] <= '0;
		end else if (en) begin
			line_a[0] <= side_a_in;
			for (int n = 1; n < DIV_QB; n++) line_a[n] <= line_a[n-1];
		end
	end

	// Profile polynomial
	shp_in_t          shp_w;
	side_t            sa;
	logic [SUM_W-1:0] num_w, den_w;

	always_comb begin
		sa          = line_a[DIV_QB-1];
		shp_w.x     = u_q;
		shp_w.a     = sa.azero ? '0 : (sa.aclamp ? WONE : a_qt);
		shp_w.b     = sa.bzero ? '0 : (sa.bclamp ? WONE : b_qt);
		shp_w.lj    = sa.lj;
		shp_w.la    = sa.la;
		shp_w.mode  = sa.mode;
	end

	scr_shape u_shape (
		.clk  (clk),
		.en   (en),
		.din  (shp_w),
		.num  (num_w),
		.den  (den_w)
	);

	side_t line_b [SHP_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < SHP_LAT; n++) line_b[n] <= '0;
		end else if (en) begin
			line_b[0] <= sa;
			for (int n = 1; n < SHP_LAT; n++) line_b[n] <= line_b[n-1];
		end
	end

	// Ratio operands
	side_t             side_b_w;
	side_t             side_s37;
	logic [DIV_NW-1:0] dvd_s37;
	logic [DIV_DW-1:0] dvs_s37;

	always_comb begin
		side_b_w    = line_b[SHP_LAT-1];
		side_b_w.dz = den_w == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s37 <= '0;
		end else if (en) begin
			side_s37 <= side_b_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s37 <= (DIV_NW'(num_w) << FRAC_BITS) + DIV_NW'(den_w);
			dvs_s37 <= DIV_DW'(den_w) << 1;
		end
	end

	logic [DIV_QB-1:0] p_q;

	scr_div u_div_p (
		.clk  (clk),
		.en   (en),
		.num  (dvd_s37),
		.den  (dvs_s37),
		.quot (p_q)
	);

	side_t side_c_in;
	side_t line_c [DIV_QB];

	always_comb begin
		side_c_in     = side_s37;
		side_c_in.sat = DIV_CW'(dvd_s37) >= (DIV_CW'(dvs_s37) << (FRAC_BITS + 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DIV_QB; n++) line_c[n] <= '0;
		end else if (en) begin
			line_c[0] <= side_c_in;
			for (int n = 1; n < DIV_QB; n++) line_c[n] <= line_c[n-1];
		end
	end

	// Result assembly: ends of the move, then the mirrored second half.
	side_t            sc;
	logic [POS_W-1:0] ratio, p_w;
	res_t             res_w;

	always_comb begin
		sc    = line_c[DIV_QB-1];
		ratio = p_q[POS_W-1:0];
		if (sc.dz) begin
			p_w = PHALF;
		end else if (sc.sat || ratio > PONE) begin
			p_w = PONE;
		end else begin
			p_w = ratio;
		end
		if (sc.full) begin
			res_w.pos = PONE;
		end else if (sc.zero) begin
			res_w.pos = '0;
		end else if (sc.sub) begin
			res_w.pos = PONE - p_w;
		end else begin
			res_w.pos = p_w;
		end
		res_w.mode = sc.mode;
	end

	scr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en && sc.valid),
		.din    (res_w),
		.adv    (en),
		.result (result)
	);

	assign sample.ready = en;

endmodule

`default_nettype wire

// File: sv/scr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module scr_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [scr_pkg::POS_W-1:0] pos,
	input wire logic [1:0]                mode
);
	import scr_pkg::*;

	// The input side only stalls when a result is waiting and refused.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a refused result");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before it was taken");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos <= PONE))
		else $error("position ratio above 1.0");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode != 2'd3))
		else $error("profile mode out of range");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind s_curve_position_ratio_unit scr_checker u_scr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.pos       (result.position_ratio),
	.mode      (result.profile_mode)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import scr_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT  = 5000;

	class position_board;
		longint unsigned duration, count, jerk_t, accel_t;
		logic [POS_W-1:0] pos_q[$];
		mode_t mode_q[$];
		int errors;

		function new();
			duration = 65536;
			count = 101;
			jerk_t = 13107;
			accel_t = 19661;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t r, longint unsigned v);
			case (r)
				REG_DURATION: duration = v & 64'hFFFFFF;
				REG_COUNT:    count = v & 64'hFFFF;
				REG_JERK:     jerk_t = v & 64'hFFFFFF;
				REG_ACCEL:    accel_t = v & 64'hFFFFFF;
			endcase
		endfunction

		function longint unsigned mulq(longint unsigned x, longint unsigned y);
			longint unsigned p;
			p = x * y;
			return p >> WB;
		endfunction

		// Normalized distance covered at x, in the phase given by the two flags.
		function longint unsigned curve(longint unsigned x, bit lj, bit la,
				longint unsigned a, longint unsigned b);
			longint unsigned a2, a3, dx, ex;
			if (lj)
				return mulq(mulq(x, x), x);
			a2 = mulq(a, a);
			a3 = mulq(a2, a);
			if (la) begin
				dx = (x > a) ? x - a : 0;
				return a3 + 3 * mulq(a2, dx) + 3 * mulq(a, mulq(dx, dx));
			end
			ex = (x > a + b) ? x - a - b : 0;
			return a3 + 3 * mulq(a2, b) + 3 * mulq(a, mulq(b, b)) +
				mulq(3 * a2 + 6 * mulq(a, b), ex);
		endfunction

		function mode_t regime();
			if (duration < 2 * jerk_t)
				return MODE_CUBIC;
			if (duration < 2 * (jerk_t + accel_t))
				return MODE_ACCEL;
			return MODE_CRUISE;
		endfunction

		function longint unsigned rising_half(longint unsigned i, longint unsigned d, mode_t m);
			longint unsigned one, u, a, b, num, den, p;
			bit lj, la;
			one = 64'd1 << WB;
			u = ((2 * i) << WB) / d;
			a = 0;
			b = 0;
			if (duration != 0) begin
				a = ((2 * jerk_t) << WB) / duration;
				b = ((2 * accel_t) << WB) / duration;
			end
			if (a > one)
				a = one;
			if (b > one)
				b = one;
			lj = i * duration < jerk_t * d;
			la = i * duration < (jerk_t + accel_t) * d;
			num = curve(u, lj, la, a, b);
			den = curve(one, m == MODE_CUBIC, m != MODE_CRUISE, a, b);
			if (den == 0)
				return (64'd1 << FRAC_BITS) / 2;
			p = (num * (64'd1 << FRAC_BITS) + den) / (2 * den);
			return (p > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : p;
		endfunction

		function void note_sample(logic [INDEX_BITS-1:0] idx);
			longint unsigned i, d, full, pos;
			mode_t m;
			i = idx;
			full = 64'd1 << FRAC_BITS;
			d = (count > 0) ? count - 1 : 0;
			m = regime();
			if (i >= d)
				pos = full;
			else if (i == 0)
				pos = 0;
			else if (2 * i <= d)
				pos = full - rising_half(i, d, m);
			else
				pos = full - rising_half(d - i, d, m);
			// The first half is the curve itself, not its complement.
			if (i != 0 && i < d && 2 * i < d)
				pos = full - pos;
			pos_q.push_back(pos[POS_W-1:0]);
			mode_q.push_back(m);
		endfunction

		function void check_result(logic [POS_W-1:0] pos, logic [1:0] m);
			logic [POS_W-1:0] want_pos;
			mode_t want_mode;
			if (pos_q.size() == 0) begin
				$display("%0t: unexpected result pos=%0d mode=%0d", $time, pos, m);
				errors++;
				return;
			end
			want_pos = pos_q.pop_front();
			want_mode = mode_q.pop_front();
			if (pos !== want_pos) begin
				$display("%0t: position_ratio expected %0d got %0d", $time, want_pos, pos);
				errors++;
			end
			if (m !== want_mode) begin
				$display("%0t: profile_mode expected %0d got %0d", $time, want_mode, m);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	scr_in_if sample ();
	scr_out_if result ();

	s_curve_position_ratio_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample.sink),
		.result(result.source)
	);

	position_board board = new();
	int send_idle = 0;
	int recv_stall = 0;
	int quiet = 0;

	initial begin
		sample.valid = 1'b0;
		sample.sample_index = '0;
		result.ready = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			result.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (sample.valid && sample.ready)
			board.note_sample(sample.sample_index);
		if (result.valid && result.ready)
			board.check_result(result.position_ratio, result.profile_mode);
		if ((sample.valid && sample.ready) || (result.valid && result.ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_sample(logic [INDEX_BITS-1:0] idx);
		while ($urandom_range(0, 99) < send_idle) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.sample_index <= idx;
		do
			@(posedge clk);
		while (!sample.ready);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (board.pos_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [23:0] dur, logic [15:0] cnt, logic [23:0] jt,
			logic [23:0] at);
		cfg_reg_t r;
		logic [23:0] vals[4];
		vals = '{dur, {8'd0, cnt}, jt, at};
		for (int k = 0; k < 4; k++) begin
			r = cfg_reg_t'(k);
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= vals[k];
			board.set_reg(r, vals[k]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int n);
		int d;
		d = int'(board.count) - 1;
		// Start, end, both sides of the middle and the top of the field.
		send_sample(INDEX_BITS'(0));
		send_sample(INDEX_BITS'(1));
		send_sample(INDEX_BITS'(d / 2));
		send_sample(INDEX_BITS'(d / 2 + 1));
		send_sample(INDEX_BITS'((d + 1) / 2));
		send_sample(INDEX_BITS'(d - 1));
		send_sample(INDEX_BITS'(d));
		send_sample(16'hFFFF);
		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				drain();
			if ($urandom_range(0, 9) < 7)
				send_sample(INDEX_BITS'($urandom_range(0, d)));
			else
				send_sample(INDEX_BITS'($urandom_range(0, 65535)));
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 58; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 58; end
				default: begin send_idle = 25; recv_stall = 25; end
			endcase
			case (ph)
				0: ;
				1: write_regs(24'hFFFFFF, 16'hFFFF, 24'd1, 24'd0);
				2: write_regs(24'd1, 16'd2, 24'hFFFFFF, 24'hFFFFFF);
				3: write_regs(24'd65536, 16'd101, 24'd40000, 24'd0);
				4: write_regs(24'd65536, 16'd1000, 24'd13107, 24'd1000);
				5: write_regs(24'd0, 16'd50, 24'd100, 24'd100);
				6: write_regs(24'd100000, 16'hFFFF, 24'd20000, 24'd5000);
				7: write_regs(TIME_W'($urandom), INDEX_BITS'($urandom_range(2, 65535)),
					TIME_W'($urandom_range(1, 24'hFFFFFF)), TIME_W'($urandom));
				default: write_regs(TIME_W'($urandom_range(1, 24'hFFFFFF)),
					INDEX_BITS'($urandom_range(2, 300)),
					TIME_W'($urandom_range(1, 24'h7FFFF)),
					TIME_W'($urandom_range(0, 24'h7FFFF)));
			endcase
			run_phase(120);
		end
		if (board.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: files.f
sv/scr_pkg.sv
sv/scr_if.sv
sv/scr_div.sv
sv/scr_shape.sv
sv/scr_queue.sv
sv/s_curve_position_ratio_unit.sv
sv/scr_checker.sv
tb/testbench.sv
